### sv/ucfb_pkg.sv
`timescale 1ns / 1ps
// Package for the buffered UART channel: request and result payload types,
// request codes and the FIFO control struct. It has no dependencies.
package ucfb_pkg;

    typedef logic [7:0] t_byte;

    localparam logic [1:0] REQ_PUT  = 2'd0;
    localparam logic [1:0] REQ_GET  = 2'd1;
    localparam logic [1:0] REQ_LINE = 2'd2;

    localparam t_byte EMPTY_BYTE = 8'hFF;

    typedef struct packed {
        logic [1:0] req_type;
        t_byte      put_byte;
        logic [3:0] line_error;
        logic       rx_ready;
        t_byte      rx_byte;
        logic       tx_empty;
    } t_req;

    typedef struct packed {
        logic        accepted;
        t_byte       get_byte;
        logic        tx_valid;
        t_byte       tx_byte;
        logic        sending;
        logic        rx_overflowed;
        logic        rx_not_empty;
        logic [10:0] tx_level;
        logic [8:0]  rx_level;
    } t_res;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } t_fifo_ctl;

endpackage

### sv/ucfb_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results of the UART channel.
// Depends on ucfb_pkg for the payload types.
interface ucfb_req_if;
    import ucfb_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ucfb_res_if;
    import ucfb_pkg::*;

    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### sv/ucfb_fifo.sv
`timescale 1ns / 1ps
// Byte ring FIFO with a registered head byte that always shows the oldest entry.
// Depends on ucfb_pkg for the byte type and the control struct.
module ucfb_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ucfb_pkg::t_fifo_ctl         i_ctl,
    input  ucfb_pkg::t_byte             i_data,
    output ucfb_pkg::t_byte             o_head,
    output logic [$clog2(DEPTH+1)-1:0]  o_count,
    output logic [$clog2(DEPTH+1)-1:0]  o_count_next
);
    import ucfb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_byte          mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    t_byte          r_head;
    logic [AW-1:0]  wr_addr;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] ptr);
        return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_comb begin
        wr_addr  = i_ctl.flush ? '0 : r_wr_ptr;
        n_wr_ptr = i_ctl.push ? f_inc(wr_addr) : wr_addr;
        if (i_ctl.flush) begin
            n_rd_ptr = '0;
        end else if (i_ctl.pop) begin
            n_rd_ptr = f_inc(r_rd_ptr);
        end else begin
            n_rd_ptr = r_rd_ptr;
        end
        n_count = i_ctl.flush ? '0 : r_count;
        n_count = n_count + CW'(i_ctl.push) - CW'(i_ctl.pop && !i_ctl.flush);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[wr_addr] <= i_data;
        end
        if (i_ctl.push && wr_addr == n_rd_ptr) begin
            r_head <= i_data;
        end else begin
            r_head <= mem[n_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_head       = r_head;
    assign o_count      = r_count;
    assign o_count_next = n_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("FIFO count exceeds its depth.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> (r_count != '0 && !i_ctl.flush))
        else $error("FIFO popped while empty or while flushing.");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.push && !i_ctl.flush) |-> (r_count != CW'(DEPTH) || i_ctl.pop))
        else $error("FIFO pushed while full.");

    a_flush_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.flush && i_ctl.push) |=> (r_count == CW'(1) && r_head == $past(i_data)))
        else $error("FIFO flush with push did not leave exactly the new byte.");

endmodule

### sv/uart_channel_fifo_buffer.sv
`timescale 1ns / 1ps
// Buffered UART channel: a transmit and a receive byte FIFO behind one request channel.
// A request is registered when it is accepted, and its result is registered when the request is processed.
// Throughput is one request per cycle while results are taken; the FIFO head bytes are prefetched each cycle.
// Reset (synchronous, active low) empties both FIFOs and clears the sending flag.
// Depends on ucfb_pkg, ucfb_if and ucfb_fifo.
module uart_channel_fifo_buffer #(
    parameter int TX_DEPTH = 1024,
    parameter int RX_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ucfb_req_if.sink   i_req,
    ucfb_res_if.source o_res
);
    import ucfb_pkg::*;

    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);

    t_req             r_req;
    logic             r_req_valid;
    t_res             r_res, n_res;
    logic             r_res_valid;
    logic             r_busy, n_busy;
    logic             proc;
    t_fifo_ctl        tx_ctl, rx_ctl;
    t_byte            tx_head, rx_head;
    logic [TX_CW-1:0] tx_count, tx_count_next;
    logic [RX_CW-1:0] rx_count, rx_count_next;

    assign proc        = r_req_valid && (!r_res_valid || o_res.ready);
    assign i_req.ready = !r_req_valid || proc;

    always_comb begin
        n_res  = '0;
        n_busy = r_busy;
        tx_ctl = '0;
        rx_ctl = '0;
        unique case (r_req.req_type)
            REQ_PUT: begin
                if (tx_count != TX_CW'(TX_DEPTH)) begin
                    n_res.accepted = 1'b1;
                    if (!r_busy) begin
                        n_busy         = 1'b1;
                        n_res.tx_valid = 1'b1;
                        n_res.tx_byte  = r_req.put_byte;
                    end else begin
                        tx_ctl.push = proc;
                    end
                end
            end
            REQ_GET: begin
                if (rx_count == '0) begin
                    n_res.get_byte = EMPTY_BYTE;
                end else begin
                    n_res.get_byte = rx_head;
                    n_res.accepted = 1'b1;
                    rx_ctl.pop     = proc;
                end
            end
            REQ_LINE: begin
                if (r_req.line_error == '0) begin
                    if (r_req.rx_ready) begin
                        rx_ctl.push = proc;
                        if (rx_count == RX_CW'(RX_DEPTH)) begin
                            rx_ctl.flush        = proc;
                            n_res.rx_overflowed = 1'b1;
                        end
                    end
                    if (r_req.tx_empty) begin
                        if (tx_count != '0) begin
                            n_busy         = 1'b1;
                            n_res.tx_valid = 1'b1;
                            n_res.tx_byte  = tx_head;
                            tx_ctl.pop     = proc;
                        end else begin
                            n_busy = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        n_res.sending      = n_busy;
        n_res.rx_not_empty = (rx_count_next != '0);
        n_res.tx_level     = 11'(tx_count_next);
        n_res.rx_level     = 9'(rx_count_next);
    end

    ucfb_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (tx_ctl),
        .i_data       (r_req.put_byte),
        .o_head       (tx_head),
        .o_count      (tx_count),
        .o_count_next (tx_count_next)
    );

    ucfb_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (rx_ctl),
        .i_data       (r_req.rx_byte),
        .o_head       (rx_head),
        .o_count      (rx_count),
        .o_count_next (rx_count_next)
    );

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_req <= i_req.payload;
        end
        if (proc) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_res_valid <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_req_valid <= i_req.valid;
            end
            if (proc) begin
                r_res_valid <= 1'b1;
                r_busy      <= n_busy;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid   = r_res_valid;
    assign o_res.payload = r_res;

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (tx_count == '0))
        else $error("Transmit FIFO holds data while the line is idle.");

    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_ctl.push |-> r_busy)
        else $error("Transmit FIFO written while the line is idle.");

    a_tx_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.tx_valid) |-> r_res.sending)
        else $error("A byte was sent without the sending flag set.");

endmodule
